// ===== rtl/core/ucb1_arm_selector_defines.svh =====
// ----------------------------------------------------------------------------
// UCB1 arm selector assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UCB1_ARM_SELECTOR_DEFINES_SVH
`define UCB1_ARM_SELECTOR_DEFINES_SVH

// same-cycle implication
`define UCB1_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UCB1_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ucb1_pkg.sv =====
// ----------------------------------------------------------------------------
// UCB1 arm selector package
// Command codes, fixed-point constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ucb1_pkg;

   localparam logic [1:0] CMD_SEED   = 2'd0;
   localparam logic [1:0] CMD_SELECT = 2'd1;
   localparam logic [1:0] CMD_REPORT = 2'd2;

   localparam int SUM_W   = 40;
   localparam int CNT_W   = 24;
   localparam int SCORE_W = 19;

   localparam logic [16:0]      ONE_Q16   = 17'd65536;
   localparam logic [15:0]      LN2_Q16   = 16'd45426;
   localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
   localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // controller to datapath
   typedef struct packed {
      logic clr_write;
      logic latch_req;
      logic seed_write;
      logic round_inc;
      logic norm_load;
      logic norm_shift;
      logic sq_mul;
      logic sq_fold;
      logic ln_mul;
      logic ln_fin;
      logic arm_read;
      logic arm_next;
      logic div_start;
      logic sqrt_start;
      logic sqrt_step;
      logic score_eval;
      logic rep_read;
      logic rep_write;
      logic rsp_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       clr_last;
      logic [1:0] req_cmd;
      logic       norm_top;
      logic       div_done;
      logic       count_zero;
      logic       scan_more;
   } dp_status_type;

endpackage

// ===== rtl/core/ucb1_divider.sv =====
// ----------------------------------------------------------------------------
// UCB1 iterative divider
// Restoring unsigned divide, 40-bit dividend by 24-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module ucb1_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ucb1_pkg::SUM_W-1:0]   dividend,
   input  logic [ucb1_pkg::CNT_W-1:0]   divisor,
   output logic [ucb1_pkg::SUM_W-1:0]   quotient,
   output logic                         done
);
   import ucb1_pkg::*;

   localparam int CW = $clog2(SUM_W + 1);

   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] div_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff, done_ff;
   logic [CNT_W:0]   trial;
   logic             qbit;

   // trial subtract of one dividend bit
   always_comb begin
      trial  = {rem_ff, quo_ff[SUM_W-1]};
      qbit   = (trial >= {1'b0, div_ff});
      rem_in = qbit ? CNT_W'(trial - {1'b0, div_ff}) : trial[CNT_W-1:0];
      quo_in = {quo_ff[SUM_W-2:0], qbit};
   end

   // hold operands, advance one step per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         rem_ff  <= '0;
         quo_ff  <= dividend;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(SUM_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/core/ucb1_datapath.sv =====
// ----------------------------------------------------------------------------
// UCB1 datapath
// Arm store, round counter, log/divide/root units, best-score tracking and
// the result word register.
// ----------------------------------------------------------------------------
module ucb1_datapath #(
   parameter int MAX_ARMS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [6:0]                    csr_data,
   input  logic [1:0]                    req_cmd,
   input  logic [5:0]                    req_arm_index,
   input  logic [16:0]                   req_reward,
   input  ucb1_pkg::dp_cmd_type          cmd,
   output ucb1_pkg::dp_status_type       status,
   output logic [5:0]                    rsp_chosen_arm,
   output logic                          rsp_none_eligible,
   output logic [ucb1_pkg::SCORE_W-1:0]  rsp_best_score
);
   import ucb1_pkg::*;

   localparam int AW = $clog2(MAX_ARMS);
   localparam int JW = $clog2(MAX_ARMS + 1);
   localparam int MW = SUM_W + CNT_W;

   // request and configuration registers
   logic [1:0]  cmd_ff;
   logic [5:0]  arm_ff;
   logic [16:0] reward_ff;
   logic [6:0]  arms_ff;
   logic [31:0] round_ff;
   logic [5:0]  last_ff;
   logic [AW-1:0] clr_ff;

   // log unit
   logic [31:0] x_ff;
   logic [4:0]  k_ff;
   logic [15:0] frac_ff;
   logic [61:0] prod_ff;
   logic [20:0] lnv_ff;
   logic [31:0] y;

   // arm store
   logic [MW-1:0] mem [MAX_ARMS];
   logic [MW-1:0] rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [MW-1:0] wr_data;
   logic          wr_en;
   logic [SUM_W-1:0] rd_sum;
   logic [CNT_W-1:0] rd_cnt;

   // scan and score
   logic [JW-1:0] j_ff, best_idx_ff, act;
   logic          found_ff;
   logic [SCORE_W-1:0] best_ff, score;
   logic [SUM_W:0]     score_sum;
   logic [SUM_W-1:0]   mean_q, q_q;
   logic               mean_done, q_done;
   logic [63:0]        v_ff, r_ff, bit_ff, trial;

   logic [SUM_W:0]   rep_sum;
   logic             seed_ok, rep_ok;

   logic [5:0]         rsp_arm_ff;
   logic               rsp_none_ff;
   logic [SCORE_W-1:0] rsp_score_ff;

   assign rd_sum  = rd_ff[MW-1:CNT_W];
   assign rd_cnt  = rd_ff[CNT_W-1:0];
   assign seed_ok = (32'(arm_ff) < MAX_ARMS);
   assign rep_ok  = (32'(last_ff) < MAX_ARMS);
   assign act     = (32'(arms_ff) > MAX_ARMS) ? JW'(MAX_ARMS) : JW'(arms_ff);
   assign y       = prod_ff[61:30];
   assign rep_sum = {1'b0, rd_sum} + (SUM_W + 1)'(reward_ff);
   assign trial   = r_ff + bit_ff;

   always_comb begin
      score_sum = {1'b0, mean_q} + (SUM_W + 1)'(r_ff[31:0]);
      score     = (score_sum > (SUM_W + 1)'(SCORE_MAX)) ? SCORE_MAX
                                                         : score_sum[SCORE_W-1:0];
   end

   // store write port: clearing pass, seed, or reward report
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      rd_addr = cmd.rep_read ? AW'(last_ff) : AW'(j_ff);
      if (cmd.clr_write) begin
         wr_en = 1'b1;
      end else if (cmd.seed_write) begin
         wr_en   = seed_ok;
         wr_addr = AW'(arm_ff);
         wr_data = {SUM_W'(reward_ff), CNT_W'(1)};
      end else if (cmd.rep_write) begin
         wr_en   = rep_ok;
         wr_addr = AW'(last_ff);
         wr_data[MW-1:CNT_W] = rep_sum[SUM_W] ? SUM_MAX : rep_sum[SUM_W-1:0];
         wr_data[CNT_W-1:0]  = (rd_cnt == CNT_MAX) ? CNT_MAX : rd_cnt + 1'b1;
      end
   end

   // arm store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.arm_read || cmd.rep_read) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         arms_ff  <= 7'd64;
         round_ff <= '0;
         last_ff  <= '0;
         clr_ff   <= '0;
         j_ff     <= '0;
         found_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            arms_ff <= csr_data;
         end
         if (cmd.clr_write) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.seed_write && seed_ok) begin
            round_ff <= 32'd1;
         end
         if (cmd.round_inc && (round_ff != '1)) begin
            round_ff <= round_ff + 1'b1;
         end
         if (cmd.ln_fin) begin
            j_ff     <= '0;
            found_ff <= 1'b0;
         end
         if (cmd.arm_next) begin
            j_ff <= j_ff + 1'b1;
         end
         if (cmd.score_eval) begin
            j_ff <= j_ff + 1'b1;
            if (!found_ff || (score > best_ff)) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.rsp_load && (cmd_ff == CMD_SELECT) && found_ff) begin
            last_ff <= 6'(best_idx_ff);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         cmd_ff    <= req_cmd;
         arm_ff    <= req_arm_index;
         reward_ff <= (req_reward > ONE_Q16) ? ONE_Q16 : req_reward;
      end
      // normalize round count so its top bit lands in bit 31
      if (cmd.norm_load) begin
         x_ff    <= round_ff;
         k_ff    <= 5'd31;
         frac_ff <= '0;
      end
      if (cmd.norm_shift) begin
         x_ff <= {x_ff[30:0], 1'b0};
         k_ff <= k_ff - 1'b1;
      end
      // square and fold for one log2 fraction bit
      if (cmd.sq_mul) begin
         prod_ff <= {31'd0, x_ff[31:1]} * {31'd0, x_ff[31:1]};
      end
      if (cmd.sq_fold) begin
         x_ff    <= y[31] ? {y[31:1], 1'b0} : {y[30:0], 1'b0};
         frac_ff <= {frac_ff[14:0], y[31]};
      end
      if (cmd.ln_mul) begin
         prod_ff <= 62'({k_ff, frac_ff}) * 62'(LN2_Q16);
      end
      if (cmd.ln_fin) begin
         lnv_ff <= prod_ff[36:16];
      end
      // restoring square root, one result bit per step
      if (cmd.sqrt_start) begin
         v_ff   <= 64'(q_q);
         r_ff   <= '0;
         bit_ff <= 64'd1 << 62;
      end
      if (cmd.sqrt_step) begin
         if (v_ff >= trial) begin
            v_ff <= v_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.score_eval && (!found_ff || (score > best_ff))) begin
         best_ff     <= score;
         best_idx_ff <= j_ff;
      end
      // build the result word
      if (cmd.rsp_load) begin
         rsp_none_ff  <= 1'b0;
         rsp_score_ff <= '0;
         case (cmd_ff)
            CMD_SELECT: begin
               rsp_arm_ff   <= found_ff ? 6'(best_idx_ff) : 6'd0;
               rsp_none_ff  <= !found_ff;
               rsp_score_ff <= found_ff ? best_ff : '0;
            end
            CMD_REPORT: begin
               rsp_arm_ff <= last_ff;
            end
            default: begin
               rsp_arm_ff <= arm_ff;
            end
         endcase
      end
   end

   // mean = sum / count and q = (2 ln n << 16) / count, run side by side
   ucb1_divider u_div_mean (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_sum),
      .divisor  (rd_cnt),
      .quotient (mean_q),
      .done     (mean_done)
   );

   ucb1_divider u_div_q (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({2'b00, lnv_ff, 17'd0}),
      .divisor  (rd_cnt),
      .quotient (q_q),
      .done     (q_done)
   );

   always_comb begin
      status.clr_last   = (clr_ff == AW'(MAX_ARMS - 1));
      status.req_cmd    = cmd_ff;
      status.norm_top   = x_ff[31];
      status.div_done   = mean_done && q_done;
      status.count_zero = (rd_cnt == '0);
      status.scan_more  = (j_ff < act);
   end

   assign rsp_chosen_arm    = rsp_arm_ff;
   assign rsp_none_eligible = rsp_none_ff;
   assign rsp_best_score    = rsp_score_ff;

endmodule

// ===== rtl/core/ucb1_ctrl.sv =====
// ----------------------------------------------------------------------------
// UCB1 controller
// Sequences the clearing pass, command decode, log, arm scan and result word.
// ----------------------------------------------------------------------------
`include "ucb1_arm_selector_defines.svh"

module ucb1_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output ucb1_pkg::dp_cmd_type     cmd,
   input  ucb1_pkg::dp_status_type  status
);
   import ucb1_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_REP, S_NORM_LOAD, S_NORM, S_SQ_MUL, S_SQ_FOLD,
      S_LN_MUL, S_LN_FIN, S_SCAN, S_ARM_CHK, S_DIV, S_SQRT, S_EVAL, S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] step_ff;
   logic       rsp_valid_ff;

   // decode commands from state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.req_cmd)
               CMD_SEED: begin
                  cmd.seed_write = 1'b1;
                  state_in       = S_DONE;
               end
               CMD_SELECT: begin
                  cmd.round_inc = 1'b1;
                  state_in      = S_NORM_LOAD;
               end
               CMD_REPORT: begin
                  cmd.rep_read = 1'b1;
                  state_in     = S_REP;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_REP: begin
            cmd.rep_write = 1'b1;
            state_in      = S_DONE;
         end
         S_NORM_LOAD: begin
            cmd.norm_load = 1'b1;
            state_in      = S_NORM;
         end
         S_NORM: begin
            if (status.norm_top) state_in = S_SQ_MUL;
            else cmd.norm_shift = 1'b1;
         end
         S_SQ_MUL: begin
            cmd.sq_mul = 1'b1;
            state_in   = S_SQ_FOLD;
         end
         S_SQ_FOLD: begin
            cmd.sq_fold = 1'b1;
            state_in    = (step_ff == 5'd15) ? S_LN_MUL : S_SQ_MUL;
         end
         S_LN_MUL: begin
            cmd.ln_mul = 1'b1;
            state_in   = S_LN_FIN;
         end
         S_LN_FIN: begin
            cmd.ln_fin = 1'b1;
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_more) begin
               cmd.arm_read = 1'b1;
               state_in     = S_ARM_CHK;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ARM_CHK: begin
            if (status.count_zero) begin
               cmd.arm_next = 1'b1;
               state_in     = S_SCAN;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (step_ff == 5'd31) state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.score_eval = 1'b1;
            state_in       = S_SCAN;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state, step count and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.sq_fold) begin
            step_ff <= (step_ff == 5'd15) ? 5'd0 : step_ff + 1'b1;
         end
         if (cmd.sqrt_step) begin
            step_ff <= step_ff + 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `UCB1_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, req_stall, "accept did not start work")
   `UCB1_ASSERT_SAME(a_load_free, cmd.rsp_load, !rsp_valid_ff || !rsp_stall, "result word overwritten")
   `UCB1_ASSERT_NEXT(a_div_restart, cmd.div_start, !status.div_done, "divider done at start")

endmodule

// ===== rtl/core/ucb1_arm_selector.sv =====
// Seed and report each return one result word; an unknown command returns none.
// Select runs the log, then the two 40-step dividers and the 32-step root for
// each arm with a nonzero count; an arm with a zero count is skipped.
// One word at a time: the next is taken once the result is queued.
// Reset: a clearing pass sweeps every arm store entry, stall high.
// ----------------------------------------------------------------------------
// UCB1 arm selector top level
// Seeds arms, picks the arm with the highest upper confidence score, and
// credits rewards to the last chosen arm.
// ----------------------------------------------------------------------------
module ucb1_arm_selector #(
   parameter int MAX_ARMS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [6:0]                    csr_arms_in_use,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [5:0]                    req_arm_index,
   input  logic [16:0]                   req_reward,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [5:0]                    rsp_chosen_arm,
   output logic                          rsp_none_eligible,
   output logic [ucb1_pkg::SCORE_W-1:0]  rsp_best_score
);
   import ucb1_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   ucb1_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .status    (status)
   );

   ucb1_datapath #(.MAX_ARMS(MAX_ARMS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_valid),
      .csr_data          (csr_arms_in_use),
      .req_cmd           (req_cmd),
      .req_arm_index     (req_arm_index),
      .req_reward        (req_reward),
      .cmd               (cmd),
      .status            (status),
      .rsp_chosen_arm    (rsp_chosen_arm),
      .rsp_none_eligible (rsp_none_eligible),
      .rsp_best_score    (rsp_best_score)
   );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UCB1 arm selector testbench
// Drives seed, select and report words with random gaps and back pressure,
// predicts every result with a local fixed-point scorer and checks each field.
// ----------------------------------------------------------------------------
module tb_top;
   import ucb1_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int NUM_ARMS = 64;
   localparam int SETTLE_CYCLES = 100;

   typedef struct {
      logic [5:0]         arm;
      logic               none;
      logic [SCORE_W-1:0] score;
   } pick_type;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [6:0]         csr_arms_in_use;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [5:0]         req_arm_index;
   logic [16:0]        req_reward;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [5:0]         rsp_chosen_arm;
   logic               rsp_none_eligible;
   logic [SCORE_W-1:0] rsp_best_score;

   // scorer state
   logic [SUM_W-1:0] arm_sum [NUM_ARMS];
   logic [CNT_W-1:0] arm_plays [NUM_ARMS];
   logic [31:0]      rounds;
   logic [5:0]       last_pick;
   logic [6:0]       arm_limit;

   pick_type pending_picks[$];
   int       errors = 0;
   int       hold_cycles = 0;
   int       long_hold = 0;

   ucb1_arm_selector i_dut (.*);

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // natural log in Q.16 by repeated squaring of the normalized mantissa
   function automatic logic [63:0] ln_fixed(logic [31:0] n);
      logic [63:0] x;
      logic [63:0] frac;
      int k;
      frac = 0;
      k = 0;
      if (n == 0) return 0;
      for (int i = 31; i >= 0; i--) begin
         if (n[i]) begin
            k = i;
            break;
         end
      end
      x = (k <= 30) ? (64'(n) << (30 - k)) : (64'(n) >> (k - 30));
      for (int i = 0; i < 16; i++) begin
         x = (x * x) >> 30;
         if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            frac |= 64'd1 << (15 - i);
         end
      end
      return (((64'(k) << 16) | frac) * 64'(LN2_Q16)) >> 16;
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // advance the scorer by one word; returns 0 when the word has no result
   function automatic bit predict_pick(logic [1:0] cmd, logic [5:0] idx,
                                       logic [16:0] rew, output pick_type p);
      logic [63:0] r;
      logic [63:0] lnv;
      logic [63:0] mean;
      logic [63:0] q;
      logic [63:0] score;
      logic [63:0] best;
      logic [63:0] s;
      int active;
      bit found;
      r = (rew > ONE_Q16) ? 64'(ONE_Q16) : 64'(rew);
      p.arm = 0;
      p.none = 0;
      p.score = 0;
      best = 0;
      found = 0;
      case (cmd)
         CMD_SEED: begin
            arm_plays[idx] = 1;
            arm_sum[idx] = SUM_W'(r);
            rounds = 1;
            p.arm = idx;
         end
         CMD_SELECT: begin
            active = (arm_limit > NUM_ARMS) ? NUM_ARMS : arm_limit;
            if (rounds != 32'hFFFF_FFFF) rounds++;
            lnv = ln_fixed(rounds);
            for (int j = 0; j < active; j++) begin
               if (arm_plays[j] == 0) continue;
               mean = 64'(arm_sum[j]) / 64'(arm_plays[j]);
               q = ((2 * lnv) << 16) / 64'(arm_plays[j]);
               score = mean + int_root(q);
               if (score > 64'(SCORE_MAX)) score = 64'(SCORE_MAX);
               if (!found || score > best) begin
                  found = 1;
                  best = score;
                  p.arm = 6'(j);
               end
            end
            if (found) begin
               last_pick = p.arm;
               p.score = SCORE_W'(best);
            end else begin
               p.none = 1;
            end
         end
         CMD_REPORT: begin
            s = 64'(arm_sum[last_pick]) + r;
            arm_sum[last_pick] = (s > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
            if (arm_plays[last_pick] != CNT_MAX) arm_plays[last_pick]++;
            p.arm = last_pick;
         end
         default: return 0;
      endcase
      return 1;
   endfunction

   // offer one word, hold it until taken, then maybe leave a gap
   task automatic send_word(logic [1:0] cmd, logic [5:0] idx, logic [16:0] rew);
      pick_type p;
      int roll;
      int gap;
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_arm_index <= idx;
      req_reward <= rew;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (predict_pick(cmd, idx, rew, p)) pending_picks.push_back(p);
      roll = $urandom_range(0, 99);
      gap = (roll < 55) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_picks();
      req_valid <= 1'b0;
      while (pending_picks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write the active arm count while the block is idle
   task automatic set_arm_limit(logic [6:0] v);
      drain_picks();
      csr_valid <= 1'b1;
      csr_arms_in_use <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      arm_limit = v;
   endtask

   // count down the long receiver hold
   always @(posedge clock) begin
      if (long_hold > 0) long_hold <= long_hold - 1;
   end

   // receive results, check fields, and stall at random or on request
   always @(posedge clock) begin
      pick_type p;
      int roll;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_picks.size() == 0) begin
            $display("%0t: unexpected word arm=%0d none=%0b score=%0d", $time,
                     rsp_chosen_arm, rsp_none_eligible, rsp_best_score);
            errors++;
         end else begin
            p = pending_picks.pop_front();
            if (rsp_chosen_arm !== p.arm || rsp_none_eligible !== p.none ||
                rsp_best_score !== p.score) begin
               $display("%0t: mismatch expected arm=%0d none=%0b score=%0d", $time,
                        p.arm, p.none, p.score);
               $display("%0t:          actual   arm=%0d none=%0b score=%0d", $time,
                        rsp_chosen_arm, rsp_none_eligible, rsp_best_score);
               errors++;
            end
         end
      end
      roll = $urandom_range(0, 99);
      if (long_hold > 0) begin
         rsp_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (roll < 70) ? 1'b0 : (roll < 97) ? 1'b1 : 1'b1;
         if (roll >= 97) hold_cycles <= $urandom_range(5, 30);
      end
   end

   task automatic test_directed();
      send_word(CMD_SELECT, 6'd0, 17'd0);         // nothing seeded: no arm
      send_word(CMD_REPORT, 6'd0, 17'd40000);     // credit before any select
      send_word(CMD_SEED, 6'd0, 17'd0);
      send_word(CMD_SEED, 6'd63, 17'h1FFFF);      // reward above one clips
      send_word(CMD_SELECT, 6'd0, 17'd0);         // round two after the seeds
      send_word(CMD_NONE, 6'h2A, 17'h15555);      // unknown command, no word
      send_word(CMD_SEED, 6'd5, 17'd30000);
      send_word(CMD_SEED, 6'd6, 17'd30000);       // tie with arm 5
      send_word(CMD_SELECT, 6'd0, 17'd0);
      send_word(CMD_REPORT, 6'd0, ONE_Q16);
      send_word(CMD_REPORT, 6'd21, 17'h0AAAA);
      send_word(CMD_SELECT, 6'd63, 17'h1FFFF);
      send_word(CMD_SELECT, 6'd0, 17'd0);
   endtask

   task automatic test_limits();
      logic [6:0] lims [5] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd7};
      foreach (lims[i]) begin
         set_arm_limit(lims[i]);
         send_word(CMD_SELECT, 6'd0, 17'd0);
         send_word(CMD_REPORT, 6'd0, 17'($urandom_range(0, 131071)));
         send_word(CMD_SELECT, 6'd0, 17'd0);
      end
   endtask

   // seeded rounds of select and report, with some noise words mixed in
   task automatic test_random();
      int roll;
      for (int n = 0; n < 170; n++) begin
         if (n == 90) set_arm_limit(7'($urandom_range(1, 127)));
         if (n == 130) set_arm_limit(7'd12);
         roll = $urandom_range(0, 99);
         if (roll < 12)
            send_word(CMD_SEED, 6'($urandom_range(0, 15)),
                      17'($urandom_range(0, 131071)));
         else if (roll < 50)
            send_word(CMD_SELECT, 6'($urandom), 17'($urandom));
         else if (roll < 92)
            send_word(CMD_REPORT, 6'($urandom),
                      (roll < 60) ? 17'($urandom) : 17'($urandom_range(0, 65536)));
         else if (roll < 96)
            send_word(CMD_NONE, 6'($urandom), 17'($urandom));
         else
            send_word(CMD_SEED, 6'($urandom), 17'($urandom));
      end
   endtask

   // hold the result side while words keep coming so the input backs up
   task automatic test_backpressure();
      drain_picks();
      long_hold = 400;
      for (int n = 0; n < 10; n++)
         send_word((n % 2) ? CMD_REPORT : CMD_SEED, 6'(n), 17'($urandom));
   endtask

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_arms_in_use = 7'd64;
      req_valid = 1'b0;
      req_cmd = CMD_SEED;
      req_arm_index = 0;
      req_reward = 0;
      rsp_stall = 1'b0;
      arm_limit = 7'd64;
      rounds = 0;
      last_pick = 0;
      for (int i = 0; i < NUM_ARMS; i++) begin
         arm_sum[i] = 0;
         arm_plays[i] = 0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      test_random();
      test_backpressure();
      set_arm_limit(7'd64);
      send_word(CMD_SELECT, 6'd0, 17'd0);
      drain_picks();
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ucb1_pkg.sv
rtl/core/ucb1_divider.sv
rtl/core/ucb1_datapath.sv
rtl/core/ucb1_ctrl.sv
rtl/core/ucb1_arm_selector.sv
verif/tb_top.sv
